>>> rtl/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef struct packed {
    logic                      command;
    logic signed [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] head_value;
  } out_res_t;

  // per-cycle shift control broadcast to every cell
  typedef struct packed {
    logic ins_en;  // insert: hold / take value / take left neighbor
    logic del_en;  // delete: hold / take right neighbor
  } cell_ctl_t;

endpackage

>>> rtl/spq_cell.sv
module spq_cell import spq_pkg::*; #(
  parameter int IDX   = 0,
  parameter int OCC_W = 7
) (
  input  logic                      clk,
  input  logic                      cmp_en,
  input  logic signed [VALUE_W-1:0] cmp_value,
  input  logic [OCC_W-1:0]          occ,
  input  cell_ctl_t                 ctl,
  input  logic signed [VALUE_W-1:0] upd_value,
  input  logic                      left_gt,
  input  logic signed [VALUE_W-1:0] left_data,
  input  logic signed [VALUE_W-1:0] right_data,
  output logic                      gt,
  output logic                      eq,
  output logic signed [VALUE_W-1:0] data,
  output logic signed [VALUE_W-1:0] data_nxt
);

  localparam logic [OCC_W-1:0] IDX_C = OCC_W'(IDX);

  logic signed [VALUE_W-1:0] data_r;
  logic                      gt_r;
  logic                      eq_r;
  logic                      valid;

  assign valid = IDX_C < occ;

  // gt: the stored entry outranks the request value (stays in place)
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_en && !gt_r) begin
      data_nxt = left_gt ? upd_value : left_data;
    end else if (ctl.del_en && !gt_r) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmp_en) begin
      gt_r <= valid && (cmp_value < data_r);
      eq_r <= valid && (cmp_value == data_r);
    end
  end

  assign gt   = gt_r;
  assign eq   = eq_r;
  assign data = data_r;

endmodule

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue: up to CAPACITY signed 32-bit values kept in
// descending order in a row of cells, largest at cell 0.
//
// Request channel: in_req (command, value) is taken on a rising edge with
// start high and busy low. Insert places the value ahead of equal entries;
// delete removes the first entry equal to the value and closes the gap.
//
// Result channel: out_res (status, count, head_value) is presented for one
// cycle with out_valid high, one result per request. There is no
// backpressure; the receiver must take it in that cycle.
//
// Timing: the edge that accepts a request also latches every cell's compare
// flags; the next edge shifts the row and registers the result, so
// out_valid is high in the cycle after that. busy is high for one cycle
// after each accept, so a new request is not taken until the two-step
// compare-then-shift through the cell row is through.
//
// Reset (rst_n low, synchronous) empties the queue and clears busy and
// out_valid. Cell contents are not cleared; slots above the count are
// never read.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam logic [OCC_W-1:0] CAP_C = OCC_W'(CAPACITY);

  typedef enum logic {S_IDLE, S_UPDATE} state_t;

  state_t                    state_r;
  logic                      accept;
  logic                      cmd_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [OCC_W-1:0]          occ_r;
  logic [OCC_W-1:0]          occ_nxt;
  logic                      out_valid_r;
  out_res_t                  out_res_r;

  logic signed [VALUE_W-1:0] cell_data [CAPACITY];
  logic signed [VALUE_W-1:0] cell_nxt  [CAPACITY];
  logic [CAPACITY-1:0]       gt_vec;
  logic [CAPACITY-1:0]       eq_vec;

  logic                      full;
  logic                      found;
  logic [1:0]                status;
  cell_ctl_t                 ctl;
  logic [OCC_W+COUNT_W-1:0]  count_ext;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_UPDATE);

  assign full  = (occ_r == CAP_C);
  assign found = |eq_vec;   // eq flags are already gated by each cell's valid

  // decide the request outcome in the update cycle
  always_comb begin
    ctl     = '0;
    occ_nxt = occ_r;
    status  = ST_OK;
    if (cmd_r == CMD_INSERT) begin
      if (full) begin
        status = ST_OVERFLOW;
      end else begin
        ctl.ins_en = busy;
        occ_nxt    = occ_r + 1'b1;
      end
    end else begin
      if (occ_r == '0) begin
        status = ST_EMPTY;
      end else if (!found) begin
        status = ST_NOTFOUND;
      end else begin
        ctl.del_en = busy;
        occ_nxt    = occ_r - 1'b1;
      end
    end
  end

  // count field is the occupancy's low bits
  assign count_ext = {{COUNT_W{1'b0}}, occ_nxt};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                      left_gt;
      logic signed [VALUE_W-1:0] left_data;
      logic signed [VALUE_W-1:0] right_data;

      if (gi == 0) begin : g_first
        assign left_gt   = 1'b1;
        assign left_data = value_r;
      end else begin : g_mid
        assign left_gt   = gt_vec[gi-1];
        assign left_data = cell_data[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_data = cell_data[gi];
      end else begin : g_inner
        assign right_data = cell_data[gi+1];
      end

      spq_cell #(
        .IDX   (gi),
        .OCC_W (OCC_W)
      ) u_cell (
        .clk        (clk),
        .cmp_en     (accept),
        .cmp_value  (in_req.value),
        .occ        (occ_r),
        .ctl        (ctl),
        .upd_value  (value_r),
        .left_gt    (left_gt),
        .left_data  (left_data),
        .right_data (right_data),
        .gt         (gt_vec[gi]),
        .eq         (eq_vec[gi]),
        .data       (cell_data[gi]),
        .data_nxt   (cell_nxt[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_req.command;
      value_r <= in_req.value;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state_r              <= S_IDLE;
          occ_r                <= occ_nxt;
          out_valid_r          <= 1'b1;
          out_res_r.status     <= status;
          out_res_r.count      <= count_ext[COUNT_W-1:0];
          out_res_r.head_value <= (occ_nxt != '0) ? cell_nxt[0] : '0;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> tb/sv/queue_result_checker.sv
module queue_result_checker import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  in_req_t  in_req,
  input  logic     out_valid,
  input  out_res_t out_res,
  output int       fail_count,
  output int       outstanding
);

  // shadow of the sorted store, largest first
  logic signed [VALUE_W-1:0] held_vals[$];
  out_res_t expected_results[$];
  out_res_t want;

  function automatic out_res_t predict_result(input in_req_t req);
    out_res_t res;
    int pos;
    pos = 0;
    if (req.command == CMD_INSERT) begin
      if (held_vals.size() >= CAPACITY_DEF) begin
        res.status = ST_OVERFLOW;
      end else begin
        // new value goes ahead of equal entries
        while (pos < held_vals.size() && req.value < held_vals[pos]) pos++;
        held_vals.insert(pos, req.value);
        res.status = ST_OK;
      end
    end else if (held_vals.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      while (pos < held_vals.size() && held_vals[pos] != req.value) pos++;
      if (pos == held_vals.size()) begin
        res.status = ST_NOTFOUND;
      end else begin
        held_vals.delete(pos);
        res.status = ST_OK;
      end
    end
    res.count = COUNT_W'(held_vals.size());
    res.head_value = (held_vals.size() > 0) ? held_vals[0] : '0;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result st=%0d cnt=%0d head=%0d", $time,
                   out_res.status, out_res.count, out_res.head_value);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_res !== want) begin
            $display("%0t: mismatch expected st=%0d cnt=%0d head=%0d, actual st=%0d cnt=%0d head=%0d",
                     $time, want.status, want.count, want.head_value,
                     out_res.status, out_res.count, out_res.head_value);
            fail_count++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_result(in_req));
      outstanding = expected_results.size();
    end
  end

endmodule

>>> tb/sv/sorted_priority_queue_tb.sv
module sorted_priority_queue_tb import spq_pkg::*;;

  localparam int RAND_REQUESTS = 1650;
  localparam int BLOCK_LEN     = 100;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh80000000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_res_t out_res;
  int       fail_count;
  int       outstanding;
  int       cycles;
  int       idle_pct;

  // values recently inserted, so deletes often find a match
  logic signed [VALUE_W-1:0] recent[$];

  sorted_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  // predicts every accepted request and scores the result strobes
  queue_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog: a hung handshake or a missing result ends here
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one request from a falling edge and hold it until an edge with
  // busy low takes it. busy only moves on rising edges, so the level seen at
  // the falling edge is the one the next rising edge will act on. Returns at
  // a falling edge, ready for the next drive.
  task automatic send_request(input logic cmd, input logic signed [VALUE_W-1:0] v);
    in_req_t req;
    logic stall;
    req.command = cmd;
    req.value = v;
    start <= 1'b1;
    in_req <= req;
    do begin
      stall = busy;
      @(posedge clk);
      @(negedge clk);
    end while (stall);
    if (cmd == CMD_INSERT) begin
      recent.push_back(v);
      if (recent.size() > 32) void'(recent.pop_front());
    end
  endtask

  // random gap on the sender side before the next request
  task automatic sender_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  // most often a small pool so equal values and delete hits are common,
  // some field extremes, the rest full-range
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $signed($urandom_range(0, 16)) - 8;
    if (r < 60) begin
      case ($urandom_range(0, 4))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_delete_value();
    if (recent.size() > 0 && $urandom_range(0, 1))
      return recent[$urandom_range(0, recent.size() - 1)];
    return pick_value();
  endfunction

  initial begin
    int ins_pct;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    idle_pct = 19;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: delete on empty, extremes, equal values, miss, drain to empty
    send_request(CMD_DELETE, 0);
    send_request(CMD_INSERT, 0);
    send_request(CMD_INSERT, VAL_MAX);
    send_request(CMD_INSERT, VAL_MIN);
    send_request(CMD_INSERT, 0);
    send_request(CMD_INSERT, -1);
    send_request(CMD_DELETE, 5);
    send_request(CMD_DELETE, VAL_MAX);
    send_request(CMD_DELETE, 0);
    send_request(CMD_DELETE, 0);
    send_request(CMD_DELETE, VAL_MIN);
    send_request(CMD_DELETE, -1);
    send_request(CMD_DELETE, -1);
    send_request(CMD_INSERT, 7);
    send_request(CMD_INSERT, 7);
    send_request(CMD_INSERT, 32'sh55555555);
    send_request(CMD_INSERT, 32'shaaaaaaaa);
    send_request(CMD_DELETE, 32'shaaaaaaaa);
    send_request(CMD_DELETE, 7);
    send_request(CMD_DELETE, 7);
    send_request(CMD_DELETE, 32'sh55555555);
    send_request(CMD_DELETE, 32'sh55555555);

    // Random part in blocks: fill-heavy blocks run into overflow,
    // drain-heavy ones into empty, balanced ones churn in the middle.
    // Sender idles 19%, then 60%, then not at all.
    for (int i = 0; i < RAND_REQUESTS; i++) begin
      if (i < RAND_REQUESTS / 3) idle_pct = 19;
      else if (i < 2 * RAND_REQUESTS / 3) idle_pct = 60;
      else idle_pct = 0;
      case ((i / BLOCK_LEN) % 3)
        0: ins_pct = 85;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      sender_gap();
      if ($urandom_range(0, 99) < ins_pct) send_request(CMD_INSERT, pick_value());
      else send_request(CMD_DELETE, pick_delete_value());
    end
    start <= 1'b0;

    // drain: every predicted result must show up before the verdict
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
